@@ rtl/core/brpl_pkg.sv @@
// Shared types and constants for the page-buffer line rasterizer.
package brpl_pkg;

    localparam int unsigned PAGE_ROWS = 8;
    localparam int unsigned PAGE_BITS = $clog2(PAGE_ROWS);
    localparam int unsigned YHI_W     = 9 - PAGE_BITS;
    localparam int unsigned QDEPTH    = 2;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_WALK,
        BS_DRAIN,
        BS_READ,
        BS_DONE
    } t_bstate;

    // Classified request as it sits in the queue
    typedef struct packed {
        t_cmd               cmd;
        logic signed [9:0]  x0;
        logic signed [9:0]  y0;
        logic signed [9:0]  x1;
        logic signed [9:0]  y1;
        logic signed [9:0]  dx;
        logic signed [9:0]  dy;
        logic               sx_neg;
        logic               sy_neg;
        logic               rd_ok;
        logic [6:0]         rd_col;
    } t_req;

endpackage

@@ rtl/core/brpl_front.sv @@
// Front end: accepts requests, decodes the command and precomputes line deltas.
module brpl_front import brpl_pkg::*; #(
    parameter int COLUMNS = 128
) (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_cmd,
    input  logic signed [8:0] i_x_start,
    input  logic signed [8:0] i_y_start,
    input  logic signed [8:0] i_x_end,
    input  logic signed [8:0] i_y_end,
    input  logic [6:0]        i_read_column,
    input  logic              i_q_full,
    output logic              o_push,
    output t_req              o_req
);

    logic signed [9:0] w_x0, w_y0, w_x1, w_y1;
    logic signed [9:0] w_diff_x, w_diff_y;

    assign w_x0 = {i_x_start[8], i_x_start};
    assign w_y0 = {i_y_start[8], i_y_start};
    assign w_x1 = {i_x_end[8], i_x_end};
    assign w_y1 = {i_y_end[8], i_y_end};

    assign w_diff_x = w_x1 - w_x0;
    assign w_diff_y = w_y1 - w_y0;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_req.cmd    = t_cmd'(i_cmd);
        o_req.x0     = w_x0;
        o_req.y0     = w_y0;
        o_req.x1     = w_x1;
        o_req.y1     = w_y1;
        // dx is the magnitude, dy the negated magnitude
        o_req.dx     = w_diff_x[9] ? -w_diff_x : w_diff_x;
        o_req.dy     = w_diff_y[9] ? w_diff_y : -w_diff_y;
        o_req.sx_neg = w_diff_x[9] || (w_diff_x == 10'sd0);
        o_req.sy_neg = w_diff_y[9] || (w_diff_y == 10'sd0);
        o_req.rd_ok  = ({2'b00, i_read_column} < 9'(COLUMNS));
        o_req.rd_col = i_read_column;
    end

endmodule

@@ rtl/core/brpl_queue.sv @@
// Short request queue between the front end and the back end.
module brpl_queue import brpl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_req o_head
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_req           r_q [QDEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PW:0]    r_count, n_count;

    assign o_full  = (r_count == (PW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_req;
        end
    end

endmodule

@@ rtl/core/brpl_back.sv @@
// Back end: page buffer, Bresenham walker and result register.
module brpl_back import brpl_pkg::*; #(
    parameter int COLUMNS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_data,
    input  logic       i_q_empty,
    input  t_req       i_q_head,
    output logic       o_q_pop,
    output logic       o_valid,
    output logic [7:0] o_column_bits,
    input  logic       i_ready
);

    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    t_bstate            r_state, n_state;
    logic [2:0]         r_page;

    logic signed [9:0]  r_wx, r_wy, r_xe, r_ye, r_dx, r_dy;
    logic signed [11:0] r_err;
    logic               r_sx_neg, r_sy_neg;

    logic [7:0]         r_mem [COLUMNS];
    logic [7:0]         r_rdata;
    logic [COLUMNS-1:0] r_colv;

    logic               r_p1_vld;
    logic [AW-1:0]      r_p1_addr;
    logic [PAGE_BITS-1:0] r_p1_bit;
    logic               r_last_vld;
    logic [AW-1:0]      r_last_addr;
    logic [7:0]         r_last_data;

    logic               r_rd_ok;
    logic [AW-1:0]      r_rd_addr;
    logic [7:0]         r_res;
    logic               r_out_vld;
    logic [7:0]         r_out_bits;

    logic               w_at_end, w_x_on, w_y_on, w_plot;
    logic               w_load_line, w_clr, w_out_ld, w_is_read;
    logic signed [12:0] w_e2, w_dx13, w_dy13;
    logic               w_step_x, w_step_y;
    logic signed [11:0] n_err;
    logic [8:0]         w_col9;
    logic [AW-1:0]      w_rd_addr;
    logic [7:0]         w_base, w_wdata;

    // Walker arithmetic
    assign w_at_end = (r_wx == r_xe) && (r_wy == r_ye);
    assign w_x_on   = !r_wx[9] && ({1'b0, r_wx[8:0]} < 10'(COLUMNS));
    assign w_y_on   = !r_wy[9] && (r_wy[8:PAGE_BITS] == YHI_W'(r_page));
    assign w_e2     = {r_err[11], r_err[11:0]} <<< 1;
    assign w_dx13   = {{3{r_dx[9]}}, r_dx};
    assign w_dy13   = {{3{r_dy[9]}}, r_dy};
    assign w_step_x = (w_e2 >= w_dy13);
    assign w_step_y = (w_e2 <= w_dx13);
    assign n_err    = r_err
                    + (w_step_x ? {{2{r_dy[9]}}, r_dy} : 12'sd0)
                    + (w_step_y ? {{2{r_dx[9]}}, r_dx} : 12'sd0);

    assign w_col9   = {2'b00, i_q_head.rd_col};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    case (i_q_head.cmd)
                        CMD_LINE: n_state = BS_WALK;
                        CMD_READ: n_state = BS_READ;
                        default:  n_state = BS_DONE;
                    endcase
                end
            end
            BS_WALK: begin
                if (w_at_end) begin
                    n_state = BS_DRAIN;
                end
            end
            BS_DRAIN: n_state = BS_DONE;
            BS_READ:  n_state = BS_DONE;
            BS_DONE: begin
                if (!r_out_vld || i_ready) begin
                    n_state = BS_IDLE;
                end
            end
            default:  n_state = BS_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_q_pop     = 1'b0;
        w_load_line = 1'b0;
        w_clr       = 1'b0;
        w_plot      = 1'b0;
        w_out_ld    = 1'b0;
        w_is_read   = 1'b0;
        w_rd_addr   = r_wx[AW-1:0];
        case (r_state)
            BS_IDLE: begin
                o_q_pop     = !i_q_empty;
                w_load_line = !i_q_empty && (i_q_head.cmd == CMD_LINE);
                w_clr       = !i_q_empty && (i_q_head.cmd == CMD_CLEAR);
                w_rd_addr   = w_col9[AW-1:0];
            end
            BS_WALK:  w_plot    = w_x_on && w_y_on;
            BS_READ:  w_is_read = 1'b1;
            BS_DONE:  w_out_ld  = !r_out_vld || i_ready;
            default:  w_plot    = 1'b0;
        endcase
    end

    // Merge with the write still in flight to the same column
    assign w_base  = (r_last_vld && (r_last_addr == r_p1_addr)) ? r_last_data :
                     (r_colv[r_p1_addr] ? r_rdata : 8'h00);
    assign w_wdata = w_base | (8'h01 << r_p1_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_IDLE;
            r_page     <= 3'd0;
            r_colv     <= '0;
            r_p1_vld   <= 1'b0;
            r_last_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= w_plot;
            if (i_cfg_we) begin
                r_page <= i_cfg_data;
            end
            if (w_clr) begin
                r_colv <= '0;
            end else if (r_p1_vld) begin
                r_colv[r_p1_addr] <= 1'b1;
            end
            if (r_state == BS_IDLE) begin
                r_last_vld <= 1'b0;
            end else if (r_p1_vld) begin
                r_last_vld <= 1'b1;
            end
            if (w_out_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Walker and payload registers
    always_ff @(posedge i_clk) begin
        if (w_load_line) begin
            r_wx     <= i_q_head.x0;
            r_wy     <= i_q_head.y0;
            r_xe     <= i_q_head.x1;
            r_ye     <= i_q_head.y1;
            r_dx     <= i_q_head.dx;
            r_dy     <= i_q_head.dy;
            r_sx_neg <= i_q_head.sx_neg;
            r_sy_neg <= i_q_head.sy_neg;
            r_err    <= {{2{i_q_head.dx[9]}}, i_q_head.dx}
                      + {{2{i_q_head.dy[9]}}, i_q_head.dy};
        end else if (r_state == BS_WALK && !w_at_end) begin
            r_err <= n_err;
            if (w_step_x) begin
                r_wx <= r_wx + (r_sx_neg ? 10'sh3FF : 10'sh001);
            end
            if (w_step_y) begin
                r_wy <= r_wy + (r_sy_neg ? 10'sh3FF : 10'sh001);
            end
        end
        r_p1_addr <= r_wx[AW-1:0];
        r_p1_bit  <= r_wy[PAGE_BITS-1:0];
        if (r_p1_vld) begin
            r_last_addr <= r_p1_addr;
            r_last_data <= w_wdata;
        end
        if (o_q_pop) begin
            r_res     <= 8'h00;
            r_rd_ok   <= i_q_head.rd_ok && (i_q_head.cmd == CMD_READ);
            r_rd_addr <= w_col9[AW-1:0];
        end else if (w_is_read) begin
            r_res <= (r_rd_ok && r_colv[r_rd_addr]) ? r_rdata : 8'h00;
        end
        if (w_out_ld) begin
            r_out_bits <= r_res;
        end
    end

    // Page buffer
    always_ff @(posedge i_clk) begin
        if (r_p1_vld) begin
            r_mem[r_p1_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    assign o_valid       = r_out_vld;
    assign o_column_bits = r_out_bits;

    a_plot_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_vld |-> (r_state == BS_WALK || r_state == BS_DRAIN))
        else $error("buffer write outside a line walk");

    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr |=> (r_colv == '0))
        else $error("clear left valid columns");

    a_walk_to_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_WALK && !w_at_end) |=> (r_state == BS_WALK))
        else $error("walk left before reaching the end point");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_DONE && r_out_vld && !i_ready) |=> (r_state == BS_DONE))
        else $error("result dropped while output stalled");

endmodule

@@ rtl/core/bresenham_page_line_rasterizer.sv @@
// Top level of the page-buffer Bresenham line rasterizer.
//
//  channel   direction  handshake             payload
//  request   in         i_valid / o_ready     i_cmd, i_x_start, i_y_start, i_x_end,
//                                             i_y_end, i_read_column
//  result    out        o_valid / i_ready     o_column_bits
//  config    in         i_cfg_we              i_cfg_data (active page)
//
// A line passes through load, a walk step per point, drain and result; a read
// passes load, read and result; clear and unused commands only load and result.
// The walker steps once per cycle, with the page buffer read in the cycle before
// its read-modify-write; that loop sets the line rate.
// Reset is synchronous and active low and clears all column valid bits at once.
// A two-entry request queue lets the front end accept while the back end
// walks, and the result register holds while the output is stalled.
module bresenham_page_line_rasterizer import brpl_pkg::*; #(
    parameter int COLUMNS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_cmd,
    input  logic signed [8:0] i_x_start,
    input  logic signed [8:0] i_y_start,
    input  logic signed [8:0] i_x_end,
    input  logic signed [8:0] i_y_end,
    input  logic [6:0]        i_read_column,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_column_bits
);

    logic w_push, w_full, w_pop, w_empty;
    t_req w_req, w_head;

    brpl_front #(
        .COLUMNS(COLUMNS)
    ) u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_read_column (i_read_column),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_req         (w_req)
    );

    brpl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_req),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    brpl_back #(
        .COLUMNS(COLUMNS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_q_empty     (w_empty),
        .i_q_head      (w_head),
        .o_q_pop       (w_pop),
        .o_valid       (o_valid),
        .o_column_bits (o_column_bits),
        .i_ready       (i_ready)
    );

endmodule

@@ verif/bresenham_page_line_rasterizer_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the page-buffer Bresenham line rasterizer.

import brpl_pkg::*;

class raster_scoreboard;
    logic [7:0] column_mem [128];
    logic [2:0] page;
    logic [7:0] column_bytes_due [$];
    int mismatches;
    int results_seen;
    int lines_drawn;
    int reads_done;
    int lit_reads;
    int clears_done;

    function new();
        foreach (column_mem[i]) column_mem[i] = '0;
        page = '0;
        mismatches = 0;
        results_seen = 0;
        lines_drawn = 0;
        reads_done = 0;
        lit_reads = 0;
        clears_done = 0;
    endfunction

    function void set_page(logic [2:0] value);
        page = value;
    endfunction

    // Drop points off screen or outside the active band; the walk goes on.
    function void mark_pixel(int x, int y);
        int base;
        base = int'(page) * 8;
        if (x >= 0 && x < 128 && y >= base && y < base + 8)
            column_mem[x][y - base] = 1'b1;
    endfunction

    function void trace_line(int xa, int ya, int xb, int yb);
        int dx, dy, sx, sy, err, e2, x, y;
        bit done;
        dx = (xb > xa) ? xb - xa : xa - xb;
        dy = -((yb > ya) ? yb - ya : ya - yb);
        sx = (xa < xb) ? 1 : -1;
        sy = (ya < yb) ? 1 : -1;
        err = dx + dy;
        x = xa;
        y = ya;
        done = 1'b0;
        while (!done) begin
            mark_pixel(x, y);
            if (x == xb && y == yb) begin
                done = 1'b1;
            end else begin
                e2 = 2 * err;
                if (e2 >= dy) begin
                    err += dy;
                    x += sx;
                end
                if (e2 <= dx) begin
                    err += dx;
                    y += sy;
                end
            end
        end
    endfunction

    function void note_request(t_cmd cmd, logic signed [8:0] xs, logic signed [8:0] ys,
                               logic signed [8:0] xe, logic signed [8:0] ye,
                               logic [6:0] col);
        logic [7:0] due;
        due = '0;
        case (cmd)
            CMD_CLEAR: begin
                foreach (column_mem[i]) column_mem[i] = '0;
                clears_done++;
            end
            CMD_LINE: begin
                trace_line(int'(xs), int'(ys), int'(xe), int'(ye));
                lines_drawn++;
            end
            CMD_READ: begin
                due = column_mem[col];
                reads_done++;
                if (due != '0) lit_reads++;
            end
            default: ;
        endcase
        column_bytes_due.push_back(due);
    endfunction

    function void check_result(logic [7:0] got);
        logic [7:0] want;
        results_seen++;
        if (column_bytes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with no request waiting, column_bits=%h", $time, got);
        end else begin
            want = column_bytes_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: column_bits mismatch, expected %h, got %h",
                             $time, want, got);
            end
        end
    endfunction

    function int pending();
        return column_bytes_due.size();
    endfunction
endclass

module bresenham_page_line_rasterizer_test;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_cmd;
    logic signed [8:0] i_x_start;
    logic signed [8:0] i_y_start;
    logic signed [8:0] i_x_end;
    logic signed [8:0] i_y_end;
    logic [6:0]        i_read_column;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [7:0]        o_column_bits;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int recent_lo = 0;
    int recent_hi = 127;

    raster_scoreboard sb = new();

    bresenham_page_line_rasterizer #(.COLUMNS(128)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_read_column (i_read_column),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_column_bits (o_column_bits)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_request(t_cmd'(i_cmd), i_x_start, i_y_start, i_x_end, i_y_end,
                                i_read_column);
            if (o_valid && i_ready)
                sb.check_result(o_column_bits);
        end
    end

    function automatic int rand9();
        return int'($urandom_range(511)) - 256;
    endfunction

    task automatic send_request(t_cmd cmd, int xs, int ys, int xe, int ye, int col);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_x_start     <= xs[8:0];
        i_y_start     <= ys[8:0];
        i_x_end       <= xe[8:0];
        i_y_end       <= ye[8:0];
        i_read_column <= col[6:0];
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Hold off new requests until every result is back and the walker is quiet.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_page(int value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[2:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_page(value[2:0]);
    endtask

    task automatic send_random();
        int r, xs, ys, xe, ye, col, base, lo, hi;
        r = $urandom_range(99);
        base = int'(sb.page) * 8;
        if (r < 3) begin
            send_request(CMD_CLEAR, rand9(), rand9(), rand9(), rand9(), $urandom_range(127));
        end else if (r < 6) begin
            send_request(CMD_NONE, rand9(), rand9(), rand9(), rand9(), $urandom_range(127));
        end else if (r < 40) begin
            // Aim half the reads at the columns the last line crossed.
            if ($urandom_range(1) == 1)
                col = $urandom_range(recent_hi, recent_lo);
            else
                col = $urandom_range(127);
            send_request(CMD_READ, rand9(), rand9(), rand9(), rand9(), col);
        end else begin
            if ($urandom_range(99) < 15) begin
                xs = rand9();
                ys = rand9();
                xe = rand9();
                ye = rand9();
            end else begin
                xs = int'($urandom_range(143)) - 8;
                ys = base + int'($urandom_range(19)) - 6;
                xe = xs + int'($urandom_range(48)) - 24;
                ye = ys + int'($urandom_range(16)) - 8;
            end
            lo = (xs < xe) ? xs : xe;
            hi = (xs < xe) ? xe : xs;
            if (lo < 0) lo = 0;
            if (hi > 127) hi = 127;
            if (lo <= hi) begin
                recent_lo = lo;
                recent_hi = hi;
            end
            send_request(CMD_LINE, xs, ys, xe, ye, $urandom_range(127));
        end
    endtask

    initial begin
        int send_table [4];
        int stall_table [4];
        send_table    = '{0, 75, 0, 7};
        stall_table   = '{0, 0, 75, 7};
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_cmd         <= CMD_CLEAR;
        i_x_start     <= '0;
        i_y_start     <= '0;
        i_x_end       <= '0;
        i_y_end       <= '0;
        i_read_column <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset contents, unused command, extremes, clipping, single point.
        send_request(CMD_READ, 0, 0, 0, 0, 0);
        send_request(CMD_NONE, -1, -1, -1, -1, 127);
        send_request(CMD_LINE, 0, 0, 127, 7, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 127);
        send_request(CMD_READ, 0, 0, 0, 0, 64);
        send_request(CMD_LINE, 5, 3, 5, 3, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 5);
        send_request(CMD_LINE, 10, -256, 10, 255, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 10);
        send_request(CMD_LINE, -256, 2, 255, 2, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 100);
        send_request(CMD_CLEAR, 0, 0, 0, 0, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 10);
        send_request(CMD_LINE, 255, 255, -256, -256, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 3);
        send_request(CMD_LINE, -20, -20, -5, -1, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 0);
        send_request(CMD_LINE, 30, 0, 33, 7, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 31);
        settle();
        write_page(7);
        send_request(CMD_LINE, 0, 56, 127, 63, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 127);
        send_request(CMD_LINE, 50, 60, 50, 200, 0);
        send_request(CMD_READ, 0, 0, 0, 0, 50);
        send_request(CMD_READ, 0, 0, 0, 0, 0);

        // Random: eight segments, one per page, two per idling profile.
        for (int seg = 0; seg < 8; seg++) begin
            settle();
            write_page((seg * 5 + 3) % 8);
            send_idle_pct  = send_table[seg / 2];
            recv_stall_pct = stall_table[seg / 2];
            for (int n = 0; n < 175; n++) begin
                if ($urandom_range(199) == 0) settle();
                send_random();
            end
        end
        settle();
        recv_stall_pct = 0;
        repeat (32) @(posedge i_clk);

        $display("Drew %0d lines, %0d clears, %0d column reads (%0d lit) on all pages.",
                 sb.lines_drawn, sb.clears_done, sb.reads_done, sb.lit_reads);
        $display("Checked %0d results, %0d mismatches.", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding.", sb.pending());
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/brpl_pkg.sv
rtl/core/brpl_front.sv
rtl/core/brpl_queue.sv
rtl/core/brpl_back.sv
rtl/core/bresenham_page_line_rasterizer.sv
verif/bresenham_page_line_rasterizer_test.sv
